// File: hw/rtl/sfr_pkg.sv
// Shared types and constants for the sum-checked frame receiver.
package sfr_pkg;

  localparam logic [7:0] HdrByte = 8'hAB;

  // Header bytes already matched when the last of the three arrives; the type byte follows
  localparam logic [1:0] HdrLast = 2'd2;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusBadHeader = 2'd1;
  localparam logic [1:0] StatusLength    = 2'd2;
  localparam logic [1:0] StatusChecksum  = 2'd3;

  typedef enum logic [2:0] {
    PhHunt = 3'd0,
    PhType = 3'd1,
    PhLenH = 3'd2,
    PhLenL = 3'd3,
    PhData = 3'd4,
    PhSum  = 3'd5
  } phase_e;

  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    logic [7:0] frame_type;
    logic [1:0] frame_status;
    logic       frame_last;
  } result_t;

endpackage

// File: hw/rtl/sfr_in_reg.sv
// Input register stage holding one received byte request.
module sfr_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_d, valid_q;
  logic [7:0] byte_d, byte_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
      byte_d  = rx_byte_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// File: hw/rtl/sfr_parser.sv
// Frame parser: phase state, running checksum and per-byte result logic.
module sfr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [15:0]         expected_length_i,
  output logic                res_valid_o,
  output sfr_pkg::result_t    res_o
);

  sfr_pkg::phase_e phase_d, phase_q;
  logic [1:0]  hdr_seen_d, hdr_seen_q;
  logic [7:0]  type_d, type_q;
  logic [15:0] len_d, len_q;
  logic [15:0] left_d, left_q;
  logic [7:0]  sum_d, sum_q;
  logic [7:0]  sum_add;
  logic [15:0] left_dec;

  assign sum_add  = sum_q + byte_i;
  assign left_dec = left_q - 16'd1;

  // Next state
  always_comb begin
    phase_d    = phase_q;
    hdr_seen_d = hdr_seen_q;
    type_d     = type_q;
    len_d      = len_q;
    left_d     = left_q;
    sum_d      = sum_q;
    case (phase_q)
      sfr_pkg::PhType: begin
        type_d  = byte_i;
        phase_d = sfr_pkg::PhLenH;
      end
      sfr_pkg::PhLenH: begin
        len_d   = {byte_i, 8'h00};
        sum_d   = byte_i;
        phase_d = sfr_pkg::PhLenL;
      end
      sfr_pkg::PhLenL: begin
        len_d   = {len_q[15:8], byte_i};
        sum_d   = sum_add;
        left_d  = expected_length_i;
        phase_d = (expected_length_i == 16'd0) ? sfr_pkg::PhSum : sfr_pkg::PhData;
      end
      sfr_pkg::PhData: begin
        sum_d  = sum_add;
        left_d = left_dec;
        if (left_dec == 16'd0) begin
          phase_d = sfr_pkg::PhSum;
        end
      end
      sfr_pkg::PhSum: begin
        phase_d    = sfr_pkg::PhHunt;
        hdr_seen_d = 2'd0;
      end
      default: begin
        // Hunt for three header bytes; any other byte restarts the hunt
        if (byte_i != sfr_pkg::HdrByte) begin
          phase_d    = sfr_pkg::PhHunt;
          hdr_seen_d = 2'd0;
        end else if (hdr_seen_q >= sfr_pkg::HdrLast) begin
          phase_d    = sfr_pkg::PhType;
          hdr_seen_d = 2'd0;
        end else begin
          phase_d    = sfr_pkg::PhHunt;
          hdr_seen_d = hdr_seen_q + 2'd1;
        end
      end
    endcase
  end

  // Result for the current byte
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.is_status    = 1'b0;
    res_o.payload_byte = 8'h00;
    res_o.frame_type   = type_q;
    res_o.frame_status = sfr_pkg::StatusOk;
    res_o.frame_last   = 1'b0;
    case (phase_q)
      sfr_pkg::PhType, sfr_pkg::PhLenH, sfr_pkg::PhLenL: begin
        res_valid_o = 1'b0;
      end
      sfr_pkg::PhData: begin
        res_valid_o        = 1'b1;
        res_o.payload_byte = byte_i;
      end
      sfr_pkg::PhSum: begin
        res_valid_o      = 1'b1;
        res_o.is_status  = 1'b1;
        res_o.frame_last = 1'b1;
        if (len_q != expected_length_i) begin
          res_o.frame_status = sfr_pkg::StatusLength;
        end else if (byte_i != sum_q) begin
          res_o.frame_status = sfr_pkg::StatusChecksum;
        end
      end
      default: begin
        if (byte_i != sfr_pkg::HdrByte) begin
          res_valid_o        = 1'b1;
          res_o.is_status    = 1'b1;
          res_o.frame_last   = 1'b1;
          res_o.frame_type   = 8'h00;
          res_o.frame_status = sfr_pkg::StatusBadHeader;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= sfr_pkg::PhHunt;
      hdr_seen_q <= 2'd0;
      type_q     <= 8'h00;
      len_q      <= 16'h0000;
      left_q     <= 16'h0000;
      sum_q      <= 8'h00;
    end else if (step_i) begin
      phase_q    <= phase_d;
      hdr_seen_q <= hdr_seen_d;
      type_q     <= type_d;
      len_q      <= len_d;
      left_q     <= left_d;
      sum_q      <= sum_d;
    end
  end

endmodule

// File: hw/rtl/sfr_out_reg.sv
// Result register stage driving the output request channel.
module sfr_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             res_valid_i,
  input  sfr_pkg::result_t res_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             space_o,
  output sfr_pkg::result_t res_o
);

  logic             valid_d, valid_q;
  sfr_pkg::result_t res_d, res_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = res_valid_i;
      res_d   = res_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/sum_checked_frame_receiver.sv
// Top level of the sum-checked frame receiver.
// An accepted byte is registered in the input stage, then its result in the result stage.
// Throughput: one byte per cycle while the result stage has room; the single parser state update per byte sets it.
// Bytes that close no payload or frame (header, type, length) give no result.
// Reset (rst_ni low, asynchronous) empties both stages, clears expected_length
// and returns the parser to hunting for the first header byte.
module sum_checked_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result request channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_status_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  frame_type_o,
  output logic [1:0]  frame_status_o,
  output logic        frame_last_o,
  // expected_length register write
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic             byte_valid;
  logic [7:0]       byte_val;
  logic             out_space;
  logic             advance;
  logic             res_valid;
  sfr_pkg::result_t res_comb;
  sfr_pkg::result_t res_reg;
  logic [15:0]      exp_len_d, exp_len_q;

  // Advance a byte from the input stage into the parser whenever the result
  // stage is empty or being drained this cycle.
  assign advance = byte_valid && out_space;

  // Hold the expected payload length until written
  assign exp_len_d = cfg_we_i ? cfg_wdata_i : exp_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= 16'h0000;
    end else begin
      exp_len_q <= exp_len_d;
    end
  end

  sfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (advance),
    .valid_o    (byte_valid),
    .byte_o     (byte_val)
  );

  // Parse one byte per advance; state moves only when the byte is consumed
  sfr_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (advance),
    .byte_i            (byte_val),
    .expected_length_i (exp_len_q),
    .res_valid_o       (res_valid),
    .res_o             (res_comb)
  );

  // Drop bytes that produce no result by loading an empty slot
  sfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res_comb),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .space_o     (out_space),
    .res_o       (res_reg)
  );

  assign is_status_o    = res_reg.is_status;
  assign payload_byte_o = res_reg.payload_byte;
  assign frame_type_o   = res_reg.frame_type;
  assign frame_status_o = res_reg.frame_status;
  assign frame_last_o   = res_reg.frame_last;

endmodule

// File: dv/frame_result_checker.sv
// Checker for the frame receiver: predicts every result and compares it on the output channel.
module frame_result_checker
  import sfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        is_status_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [7:0]  frame_type_i,
  input  logic [1:0]  frame_status_i,
  input  logic        frame_last_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          mismatch_count_o,
  output int          outstanding_o
);

  logic [15:0] exp_len_q;
  phase_e      parse_phase;
  logic [1:0]  hdr_count;
  logic [7:0]  held_type;
  logic [15:0] held_length;
  logic [15:0] bytes_left;
  logic [7:0]  running_sum;

  result_t expected_results[$];
  int      mismatches;

  assign mismatch_count_o = mismatches;

  // Advance the parser by one byte; return 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, output result_t res);
    res = '0;
    case (parse_phase)
      PhType: begin
        held_type   = b;
        parse_phase = PhLenH;
        return 1'b0;
      end
      PhLenH: begin
        held_length = {b, 8'h00};
        running_sum = b;
        parse_phase = PhLenL;
        return 1'b0;
      end
      PhLenL: begin
        held_length[7:0] = b;
        running_sum      = running_sum + b;
        bytes_left       = exp_len_q;
        parse_phase      = (bytes_left == 16'd0) ? PhSum : PhData;
        return 1'b0;
      end
      PhData: begin
        running_sum = running_sum + b;
        bytes_left  = bytes_left - 16'd1;
        if (bytes_left == 16'd0) parse_phase = PhSum;
        res.payload_byte = b;
        res.frame_type   = held_type;
        res.frame_status = StatusOk;
        return 1'b1;
      end
      PhSum: begin
        res.is_status  = 1'b1;
        res.frame_type = held_type;
        res.frame_last = 1'b1;
        if (held_length != exp_len_q) res.frame_status = StatusLength;
        else if (b != running_sum)   res.frame_status = StatusChecksum;
        else                          res.frame_status = StatusOk;
        parse_phase = PhHunt;
        hdr_count   = 2'd0;
        return 1'b1;
      end
      default: begin
        if (b != HdrByte) begin
          parse_phase      = PhHunt;
          hdr_count        = 2'd0;
          res.is_status    = 1'b1;
          res.frame_status = StatusBadHeader;
          res.frame_last   = 1'b1;
          return 1'b1;
        end
        if (hdr_count >= HdrLast) begin
          hdr_count   = 2'd0;
          parse_phase = PhType;
        end else begin
          hdr_count   = hdr_count + 2'd1;
          parse_phase = PhHunt;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic int field_diff(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t res;
    result_t want;
    if (!rst_ni) begin
      exp_len_q   = 16'd0;
      parse_phase = PhHunt;
      hdr_count   = 2'd0;
      held_type   = 8'd0;
      held_length = 16'd0;
      bytes_left  = 16'd0;
      running_sum = 8'd0;
      mismatches  = 0;
      expected_results.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) exp_len_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (parse_byte(rx_byte_i, res)) expected_results.push_back(res);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with none pending: is_status %0h payload %0h type %0h status %0h",
                 is_status_i, payload_byte_i, frame_type_i, frame_status_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          mismatches += field_diff("is_status", want.is_status, is_status_i);
          mismatches += field_diff("payload_byte", want.payload_byte, payload_byte_i);
          mismatches += field_diff("frame_type", want.frame_type, frame_type_i);
          mismatches += field_diff("frame_status", want.frame_status, frame_status_i);
          mismatches += field_diff("frame_last", want.frame_last, frame_last_i);
        end
      end
      outstanding_o <= expected_results.size();
    end
  end

endmodule

// File: dv/testbench.sv
// Top of the frame receiver testbench: stimulus, receiver pacing, watchdog and verdict.
module testbench;
  import sfr_pkg::*;

  localparam int ResetCycles   = 6;
  localparam int WatchdogLimit = 4000;  // far above the longest receiver hold-off
  localparam int HoldCycles    = 400;
  localparam int ItemBudget    = 1900;
  localparam int PhaseCount    = 12;
  localparam int SettleCycles  = 4;     // margin for the pipe to settle before a register write
  localparam int DrainCycles   = 8;

  typedef enum int {
    KindGood,
    KindLenSlip,
    KindSumSlip,
    KindCutHeader,
    KindNoise
  } frame_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        is_status_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  frame_type_o;
  logic [1:0]  frame_status_o;
  logic        frame_last_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  int          mismatch_count;
  int          outstanding;

  // Pacing knobs for the sender (in_idle_pct) and the receiver (out_idle_pct, hold_req)
  int          in_idle_pct  = 20;
  int          out_idle_pct = 20;
  bit          hold_req     = 1'b0;

  int          items_sent   = 0;
  logic [15:0] cur_len      = 16'd0;

  sum_checked_frame_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_status_o   (is_status_o),
    .payload_byte_o(payload_byte_o),
    .frame_type_o  (frame_type_o),
    .frame_status_o(frame_status_o),
    .frame_last_o  (frame_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  frame_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_status_i     (is_status_o),
    .payload_byte_i  (payload_byte_o),
    .frame_type_i    (frame_type_o),
    .frame_status_i  (frame_status_o),
    .frame_last_i    (frame_last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: drop ready at random, or hold it off for a long stretch on request
  // so that the block fills up and pushes back on the byte channel.
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one byte request and hold it until accepted. Valid stays high on return,
  // so the caller either offers the next byte or drops valid in the same step.
  task automatic send_byte(input logic [7:0] b);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Write expected_length once every pending result is out and the pipe has settled.
  task automatic write_length(input logic [15:0] v);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_len   = v;
  endtask

  // Send one frame shaped by kind, sized by the current expected_length.
  task automatic send_frame(input frame_kind_e kind);
    logic [15:0] len_field;
    logic [7:0]  sum;
    logic [7:0]  b;
    int          hdr_n;
    len_field = cur_len;
    case (kind)
      KindNoise: send_byte(8'($urandom_range(255)));
      KindCutHeader: begin
        // Break the header after zero, one or two good bytes
        hdr_n = $urandom_range(2);
        repeat (hdr_n) send_byte(HdrByte);
        b = 8'($urandom_range(255));
        if (b == HdrByte) b = ~b;
        send_byte(b);
      end
      default: begin
        if (kind == KindLenSlip) len_field = cur_len ^ 16'($urandom_range(1, 16'hFFFF));
        repeat (3) send_byte(HdrByte);
        send_byte(8'($urandom_range(255)));
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
        sum = len_field[15:8] + len_field[7:0];
        repeat (cur_len) begin
          b   = 8'($urandom_range(255));
          sum = sum + b;
          send_byte(b);
        end
        if (kind == KindSumSlip) sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
      end
    endcase
  endtask

  initial begin : stimulus
    logic [7:0]  seq[$];
    logic [15:0] next_len;
    frame_kind_e kind;
    int          pick;
    int          phase_end;

    in_valid_i  = 1'b0;
    rx_byte_i   = 8'd0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 16'd0;
    rst_ni      = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: zero-length frame, bad header bytes at the first and third header
    // positions, and a length field that disagrees with the register.
    write_length(16'd0);
    seq = '{8'hAB, 8'hAB, 8'hAB, 8'h3C, 8'h00, 8'h00, 8'h00,
            8'h00,
            8'hAB, 8'hAB, 8'h54,
            8'hAB, 8'hAB, 8'hAB, 8'hFF, 8'h00, 8'h01, 8'h01};
    foreach (seq[i]) send_byte(seq[i]);

    // Register rewritten mid-frame: payload count is latched at the length low
    // byte, the length check sees the new value.
    write_length(16'd1);
    seq = '{8'hAB, 8'hAB, 8'hAB, 8'h5A, 8'h00, 8'h01};
    foreach (seq[i]) send_byte(seq[i]);
    write_length(16'd3);
    send_byte(8'hA5);
    send_byte(8'hA6);

    // Random phases, each under its own expected_length
    for (int p = 0; p < PhaseCount; p++) begin
      case (p % 4)
        0:       next_len = (p == 0) ? 16'd0 : 16'($urandom_range(0, 1));
        1:       next_len = 16'($urandom_range(2, 6));
        2:       next_len = 16'($urandom_range(7, 20));
        default: next_len = (p == 7) ? 16'd255 : 16'($urandom_range(21, 40));
      endcase
      write_length(next_len);

      // Run one phase without idling, and one with a long receiver hold-off
      // while the sender keeps offering bytes back to back.
      in_idle_pct  = (p == 2 || p == 5) ? 0 : 20;
      out_idle_pct = (p == 2) ? 0 : 20;
      if (p == 5) hold_req = 1'b1;

      phase_end = items_sent + (ItemBudget - items_sent) / (PhaseCount - p);
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70)      kind = KindGood;
        else if (pick < 80) kind = KindLenSlip;
        else if (pick < 88) kind = KindSumSlip;
        else if (pick < 95) kind = KindCutHeader;
        else                kind = KindNoise;
        send_frame(kind);
      end
    end

    // Drain: hold valid low, wait out every pending result, then the pipe latency
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
